[hw/rtl/pptt_pkg.sv]
// shared types and constants for the pid position trajectory tracker
// used by pptt_pid and pid_position_trajectory_tracker_top
package pptt_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 24;
  localparam int LIM_W     = 31;
  localparam int LEN_W     = 11;
  localparam int SLOT_W    = 10;
  localparam int KIND_W    = 3;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 25;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int LOOP_RATE = 200;

  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POINT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HOLD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IDLE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRACK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd4;

  typedef enum logic [2:0] {
    PS_NONE,
    PS_ERR,
    PS_DER,
    PS_PROP,
    PS_INTEG,
    PS_DERIV,
    PS_SUM
  } pid_step_t;

  typedef struct packed {
    pid_step_t step;
    logic      clr_loop;
  } pid_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ERR,
    ST_DER,
    ST_PROP,
    ST_INTEG,
    ST_DERIV,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/pptt_pid.sv]
// pid arithmetic: error, derivative, clamped integrator and one shared multiplier
// sequenced step by step by the control struct from the top level; uses pptt_pkg
module pptt_pid (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  pptt_pkg::pid_ctrl_t                     ctrl,
  input  logic signed [pptt_pkg::DATA_W-1:0]      ref_pos,
  input  logic signed [pptt_pkg::DATA_W-1:0]      meas,
  input  logic        [pptt_pkg::GAIN_W-1:0]      prop_gain,
  input  logic        [pptt_pkg::GAIN_W-1:0]      integ_gain,
  input  logic        [pptt_pkg::GAIN_W-1:0]      deriv_gain,
  input  logic        [pptt_pkg::LIM_W-1:0]       integ_limit,
  output logic signed [pptt_pkg::DATA_W-1:0]      command
);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [pptt_pkg::DATA_W-1:0]  err_r, err_nxt;
  logic signed [pptt_pkg::DATA_W-1:0]  last_r, last_nxt;
  logic signed [pptt_pkg::DATA_W-1:0]  summed_r, summed_nxt;
  logic signed [pptt_pkg::DATA_W-1:0]  der_r, der_nxt;
  logic signed [pptt_pkg::PROD_W-1:0]  prod_r;
  logic signed [pptt_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [pptt_pkg::ACC_W-1:0]   acc_sh;
  logic signed [pptt_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pptt_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pptt_pkg::PROD_W-1:0]  mul_full;
  logic signed [pptt_pkg::DATA_W:0]    diff;
  logic signed [pptt_pkg::DATA_W:0]    s_sum;
  logic signed [pptt_pkg::DATA_W:0]    lim;
  logic signed [pptt_pkg::DATA_W:0]    nlim;
  logic signed [pptt_pkg::DATA_W:0]    clamped;

  always_comb begin
    diff    = (pptt_pkg::DATA_W+1)'(ref_pos) - (pptt_pkg::DATA_W+1)'(meas);
    s_sum   = (pptt_pkg::DATA_W+1)'(summed_r) + (pptt_pkg::DATA_W+1)'(err_r);
    lim     = {2'b00, integ_limit};
    nlim    = -lim;
    if (s_sum > lim) begin
      clamped = lim;
    end else if (s_sum < nlim) begin
      clamped = nlim;
    end else begin
      clamped = s_sum;
    end

    err_nxt    = err_r;
    last_nxt   = last_r;
    summed_nxt = summed_r;
    der_nxt    = der_r;
    acc_nxt    = acc_r;
    mul_a      = '0;
    mul_b      = '0;

    case (ctrl.step)
      pptt_pkg::PS_ERR: begin
        err_nxt = sat32(64'(diff));
      end
      pptt_pkg::PS_DER: begin
        mul_a      = pptt_pkg::MUL_A_W'(err_r) - pptt_pkg::MUL_A_W'(last_r);
        mul_b      = pptt_pkg::MUL_B_W'(pptt_pkg::LOOP_RATE);
        last_nxt   = err_r;
        summed_nxt = clamped[pptt_pkg::DATA_W-1:0];
      end
      pptt_pkg::PS_PROP: begin
        der_nxt = sat32(64'(prod_r));
        mul_a   = pptt_pkg::MUL_A_W'(err_r);
        mul_b   = {1'b0, prop_gain};
      end
      pptt_pkg::PS_INTEG: begin
        acc_nxt = pptt_pkg::ACC_W'(prod_r);
        mul_a   = pptt_pkg::MUL_A_W'(summed_r);
        mul_b   = {1'b0, integ_gain};
      end
      pptt_pkg::PS_DERIV: begin
        acc_nxt = acc_r + pptt_pkg::ACC_W'(prod_r);
        mul_a   = pptt_pkg::MUL_A_W'(der_r);
        mul_b   = {1'b0, deriv_gain};
      end
      pptt_pkg::PS_SUM: begin
        acc_nxt = acc_r + pptt_pkg::ACC_W'(prod_r);
      end
      default: begin
      end
    endcase

    if (ctrl.clr_loop) begin
      summed_nxt = '0;
      last_nxt   = '0;
    end
  end

  assign mul_full = mul_a * mul_b;
  // floor of the sum over 2^16
  assign acc_sh   = acc_r >>> 16;
  assign command  = sat32(64'(acc_sh));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summed_r <= '0;
      last_r   <= '0;
    end else begin
      summed_r <= summed_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    der_r  <= der_nxt;
    prod_r <= mul_full;
    acc_r  <= acc_nxt;
  end

endmodule

[hw/rtl/pid_position_trajectory_tracker_top.sv]
// top level: beat buffer, item sequencer, trajectory memory and result register
// depends on pptt_pkg and pptt_pid
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  kind, measured_angle, point_slot, value
//   out_     output     out_valid/out_stall command, reference, play_index, playing,
//                                          finished, mode
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a tick in hold or track runs the sequencer from err through sum to done, with the
// shared multiplier running derivative, proportional, integral and derivative-gain
// products in turn; start reads trajectory memory in load; others emit from idle
// a one-beat input buffer takes the next item while the sequencer works
// reset is synchronous; the trajectory memory is not cleared and needs no sweep
// a stalled output holds its result and the sequencer waits before the next emit
module pid_position_trajectory_tracker_top #(
  parameter int PATH_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pptt_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [pptt_pkg::DATA_W-1:0]   in_measured_angle,
  input  logic [pptt_pkg::SLOT_W-1:0]          in_point_slot,
  input  logic signed [pptt_pkg::DATA_W-1:0]   in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pptt_pkg::DATA_W-1:0]  out_command,
  output logic signed [pptt_pkg::DATA_W-1:0]  out_reference,
  output logic [pptt_pkg::LEN_W-1:0]           out_play_index,
  output logic                                 out_playing,
  output logic                                 out_finished,
  output logic [pptt_pkg::MODE_W-1:0]          out_mode,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pptt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pptt_pkg::DATA_W-1:0]          cfg_data
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int WW = (AW > pptt_pkg::LEN_W) ? AW : pptt_pkg::LEN_W;

  pptt_pkg::state_t state_r, state_nxt;

  logic                                buf_valid_r, buf_valid_nxt;
  logic [pptt_pkg::KIND_W-1:0]         buf_kind_r;
  logic signed [pptt_pkg::DATA_W-1:0]  buf_meas_r;
  logic [pptt_pkg::SLOT_W-1:0]         buf_slot_r;
  logic signed [pptt_pkg::DATA_W-1:0]  buf_value_r;

  logic signed [pptt_pkg::DATA_W-1:0]  cur_meas_r, cur_meas_nxt;
  logic                                load_r, load_nxt;
  logic                                fin_r, fin_nxt;

  logic signed [pptt_pkg::DATA_W-1:0]  ref_r, ref_nxt;
  logic [pptt_pkg::LEN_W-1:0]          slot_r, slot_nxt;
  logic                                active_r, active_nxt;
  logic [pptt_pkg::MODE_W-1:0]         mode_r, mode_nxt;
  logic signed [pptt_pkg::DATA_W-1:0]  held_r, held_nxt;

  logic [pptt_pkg::GAIN_W-1:0]         prop_r, prop_nxt;
  logic [pptt_pkg::GAIN_W-1:0]         integ_r, integ_nxt;
  logic [pptt_pkg::GAIN_W-1:0]         deriv_r, deriv_nxt;
  logic [pptt_pkg::LIM_W-1:0]          limit_r, limit_nxt;
  logic [pptt_pkg::LEN_W-1:0]          len_r, len_nxt;
  logic [pptt_pkg::LEN_W-1:0]          len_eff;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [pptt_pkg::DATA_W-1:0]  out_command_r;
  logic signed [pptt_pkg::DATA_W-1:0]  out_reference_r;
  logic [pptt_pkg::LEN_W-1:0]          out_play_index_r;
  logic                                out_playing_r;
  logic                                out_finished_r;
  logic [pptt_pkg::MODE_W-1:0]         out_mode_r;

  logic                                out_free;
  logic                                in_acc;
  logic                                cfg_we;
  logic                                cfg_clr;
  logic                                item_clr;
  logic                                pop;
  logic                                emit;
  logic                                emit_fin;
  logic                                is_long;
  logic                                slot_ok;
  logic                                rd_en;
  logic                                rd_zero;
  logic                                wr_en;
  logic [WW-1:0]                       rd_wide;
  logic [WW-1:0]                       wr_wide;
  logic [AW-1:0]                       rd_addr;
  logic [AW-1:0]                       wr_addr;
  logic signed [pptt_pkg::DATA_W-1:0]  rd_data_r;
  logic signed [pptt_pkg::DATA_W-1:0]  path_mem [PATH_DEPTH];

  pptt_pkg::pid_step_t                 step;
  pptt_pkg::pid_ctrl_t                 pid_ctrl;
  logic signed [pptt_pkg::DATA_W-1:0]  pid_ref;
  logic signed [pptt_pkg::DATA_W-1:0]  pid_cmd;

  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = (state_r == pptt_pkg::ST_IDLE) && !buf_valid_r;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = buf_valid_r && !pop;
  assign in_acc    = in_valid && !in_stall;

  assign len_eff = (32'(len_r) > PATH_DEPTH) ? pptt_pkg::LEN_W'(PATH_DEPTH) : len_r;
  assign slot_ok = 32'(buf_slot_r) < PATH_DEPTH;
  assign is_long = ((buf_kind_r == pptt_pkg::KIND_TICK) && (mode_r != pptt_pkg::MODE_IDLE))
                   || (buf_kind_r == pptt_pkg::KIND_START);

  assign rd_wide = rd_zero ? '0 : WW'(slot_r);
  assign wr_wide = WW'(buf_slot_r);
  assign rd_addr = rd_wide[AW-1:0];
  assign wr_addr = wr_wide[AW-1:0];

  always_comb begin
    state_nxt    = state_r;
    cur_meas_nxt = cur_meas_r;
    load_nxt     = load_r;
    fin_nxt      = fin_r;
    ref_nxt      = ref_r;
    slot_nxt     = slot_r;
    active_nxt   = active_r;
    mode_nxt     = mode_r;
    held_nxt     = held_r;
    prop_nxt     = prop_r;
    integ_nxt    = integ_r;
    deriv_nxt    = deriv_r;
    limit_nxt    = limit_r;
    len_nxt      = len_r;
    pop          = 1'b0;
    emit         = 1'b0;
    emit_fin     = 1'b0;
    item_clr     = 1'b0;
    cfg_clr      = 1'b0;
    rd_en        = 1'b0;
    rd_zero      = 1'b0;
    wr_en        = 1'b0;
    step         = pptt_pkg::PS_NONE;
    pid_ref      = ref_r;

    case (state_r)
      pptt_pkg::ST_IDLE: begin
        if (buf_valid_r && (is_long || out_free)) begin
          pop          = 1'b1;
          cur_meas_nxt = buf_meas_r;
          load_nxt     = 1'b0;
          fin_nxt      = 1'b0;
          case (buf_kind_r)
            pptt_pkg::KIND_TICK: begin
              if (mode_r != pptt_pkg::MODE_IDLE) begin
                if ((mode_r == pptt_pkg::MODE_TRACK) && active_r) begin
                  if (slot_r < len_eff) begin
                    rd_en    = 1'b1;
                    load_nxt = 1'b1;
                    slot_nxt = slot_r + 1'b1;
                  end else begin
                    active_nxt = 1'b0;
                    mode_nxt   = pptt_pkg::MODE_HOLD;
                    fin_nxt    = 1'b1;
                  end
                end
                state_nxt = pptt_pkg::ST_ERR;
              end else begin
                item_clr = 1'b1;
                emit     = 1'b1;
              end
            end
            pptt_pkg::KIND_POINT: begin
              wr_en = slot_ok;
              emit  = 1'b1;
            end
            pptt_pkg::KIND_START: begin
              rd_en      = 1'b1;
              rd_zero    = 1'b1;
              slot_nxt   = '0;
              item_clr   = 1'b1;
              active_nxt = 1'b1;
              mode_nxt   = pptt_pkg::MODE_TRACK;
              state_nxt  = pptt_pkg::ST_LOAD;
            end
            pptt_pkg::KIND_HOLD: begin
              ref_nxt    = buf_value_r;
              active_nxt = 1'b0;
              mode_nxt   = pptt_pkg::MODE_HOLD;
              emit       = 1'b1;
            end
            pptt_pkg::KIND_IDLE: begin
              active_nxt = 1'b0;
              mode_nxt   = pptt_pkg::MODE_IDLE;
              emit       = 1'b1;
            end
            pptt_pkg::KIND_CLEAR: begin
              item_clr = 1'b1;
              emit     = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      pptt_pkg::ST_LOAD: begin
        ref_nxt = rd_data_r;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = pptt_pkg::ST_IDLE;
        end
      end
      pptt_pkg::ST_ERR: begin
        pid_ref   = load_r ? rd_data_r : ref_r;
        ref_nxt   = pid_ref;
        step      = pptt_pkg::PS_ERR;
        state_nxt = pptt_pkg::ST_DER;
      end
      pptt_pkg::ST_DER: begin
        step      = pptt_pkg::PS_DER;
        state_nxt = pptt_pkg::ST_PROP;
      end
      pptt_pkg::ST_PROP: begin
        step      = pptt_pkg::PS_PROP;
        state_nxt = pptt_pkg::ST_INTEG;
      end
      pptt_pkg::ST_INTEG: begin
        step      = pptt_pkg::PS_INTEG;
        state_nxt = pptt_pkg::ST_DERIV;
      end
      pptt_pkg::ST_DERIV: begin
        step      = pptt_pkg::PS_DERIV;
        state_nxt = pptt_pkg::ST_SUM;
      end
      pptt_pkg::ST_SUM: begin
        step      = pptt_pkg::PS_SUM;
        state_nxt = pptt_pkg::ST_DONE;
      end
      pptt_pkg::ST_DONE: begin
        if (out_free) begin
          held_nxt  = pid_cmd;
          emit      = 1'b1;
          emit_fin  = fin_r;
          state_nxt = pptt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pptt_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        pptt_pkg::REG_PROP: begin
          prop_nxt = cfg_data[pptt_pkg::GAIN_W-1:0];
          cfg_clr  = 1'b1;
        end
        pptt_pkg::REG_INTEG: begin
          integ_nxt = cfg_data[pptt_pkg::GAIN_W-1:0];
          cfg_clr   = 1'b1;
        end
        pptt_pkg::REG_DERIV: begin
          deriv_nxt = cfg_data[pptt_pkg::GAIN_W-1:0];
          cfg_clr   = 1'b1;
        end
        pptt_pkg::REG_LIMIT: begin
          limit_nxt = cfg_data[pptt_pkg::LIM_W-1:0];
        end
        pptt_pkg::REG_LEN: begin
          len_nxt  = cfg_data[pptt_pkg::LEN_W-1:0];
          slot_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign buf_valid_nxt = in_acc || (buf_valid_r && !pop);
  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  assign pid_ctrl.step     = step;
  assign pid_ctrl.clr_loop = item_clr || cfg_clr;

  pptt_pid u_pid (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (pid_ctrl),
    .ref_pos     (pid_ref),
    .meas        (cur_meas_r),
    .prop_gain   (prop_r),
    .integ_gain  (integ_r),
    .deriv_gain  (deriv_r),
    .integ_limit (limit_r),
    .command     (pid_cmd)
  );

  // trajectory memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      path_mem[wr_addr] <= buf_value_r;
    end
    if (rd_en) begin
      rd_data_r <= path_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pptt_pkg::ST_IDLE;
      buf_valid_r <= 1'b0;
      load_r      <= 1'b0;
      fin_r       <= 1'b0;
      ref_r       <= '0;
      slot_r      <= '0;
      active_r    <= 1'b0;
      mode_r      <= pptt_pkg::MODE_IDLE;
      held_r      <= '0;
      prop_r      <= 24'd524288;
      integ_r     <= 24'd6554;
      deriv_r     <= 24'd131072;
      limit_r     <= 31'd6553600;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buf_valid_r <= buf_valid_nxt;
      load_r      <= load_nxt;
      fin_r       <= fin_nxt;
      ref_r       <= ref_nxt;
      slot_r      <= slot_nxt;
      active_r    <= active_nxt;
      mode_r      <= mode_nxt;
      held_r      <= held_nxt;
      prop_r      <= prop_nxt;
      integ_r     <= integ_nxt;
      deriv_r     <= deriv_nxt;
      limit_r     <= limit_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_kind_r  <= in_kind;
      buf_meas_r  <= in_measured_angle;
      buf_slot_r  <= in_point_slot;
      buf_value_r <= in_value;
    end
    cur_meas_r <= cur_meas_nxt;
    if (emit) begin
      out_command_r    <= held_nxt;
      out_reference_r  <= ref_nxt;
      out_play_index_r <= slot_nxt;
      out_playing_r    <= active_nxt;
      out_finished_r   <= emit_fin;
      out_mode_r       <= mode_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_command    = out_command_r;
  assign out_reference  = out_reference_r;
  assign out_play_index = out_play_index_r;
  assign out_playing    = out_playing_r;
  assign out_finished   = out_finished_r;
  assign out_mode       = out_mode_r;

  a_active_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (mode_r == pptt_pkg::MODE_TRACK))
    else $error("playback active outside track mode");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (slot_r <= len_eff))
    else $error("play index beyond effective path length");

  a_read_used: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> ((state_r == pptt_pkg::ST_ERR) || (state_r == pptt_pkg::ST_LOAD)))
    else $error("memory read not consumed on the following cycle");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_finished_r) |-> ((out_mode_r == pptt_pkg::MODE_HOLD) && !out_playing_r))
    else $error("finished beat without hold mode");

endmodule
